// ===== src/ssbrc_pkg.sv =====
// ----------------------------------------------------------------------------
// ssbrc_pkg
// Shared types, constants and the character-to-segment encoder for the
// seven-segment blink/refresh controller.
// ----------------------------------------------------------------------------
`default_nettype none

package ssbrc_pkg;

  localparam int DIGITS      = 3;
  localparam int TEXT_CHARS  = 6;
  localparam int DIDX_W      = $clog2(DIGITS + 1);
  localparam int SLOTS       = 3;
  localparam int SLOT_W      = $clog2(SLOTS);

  // drive slots of one tick, in emission order
  localparam logic [SLOT_W-1:0] SLOT_MODE    = SLOT_W'(0);
  localparam logic [SLOT_W-1:0] SLOT_LEVEL   = SLOT_W'(1);
  localparam logic [SLOT_W-1:0] SLOT_STARTUP = SLOT_W'(2);

  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_SET  = 1'b1;

  localparam logic WK_CTRL  = 1'b0;
  localparam logic WK_DIGIT = 1'b1;

  localparam logic [1:0] TOP_POS       = 2'd3;
  localparam logic [7:0] DOT_SEG       = 8'h80;
  localparam logic [7:0] DASH_SEG      = 8'h40;
  localparam logic [7:0] CH_DOT        = 8'h2E;
  localparam logic [7:0] CH_DASH       = 8'h2D;
  localparam logic [7:0] CH_NUL        = 8'h00;
  localparam logic [7:0] SHOWN_RST     = 8'hFF;
  localparam logic [6:0] BLINK_LIMIT   = 7'd100;
  localparam logic [6:0] BLINK_SHOW    = 7'd50;
  localparam logic [7:0] STARTUP_TICKS = 8'd200;
  localparam logic [2:0] LEVEL_RST     = 3'd7;

  localparam logic [7:0] GLYPH [36] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F,
    8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h3D, 8'h76, 8'h19, 8'h0D,
    8'h72, 8'h38, 8'h55, 8'h54, 8'h5D, 8'h73, 8'h67, 8'h50, 8'h6D, 8'h78,
    8'h3E, 8'h1C, 8'h6A, 8'h1D, 8'h6E, 8'h49
  };

  typedef logic [DIGITS-1:0][7:0] seg_buf_t;

  // one tick's worth of driver writes, up to one per slot
  typedef struct packed {
    logic [SLOTS-1:0] vld;
    logic [SLOTS-1:0] en;
    logic [SLOTS-1:0] blank;
    logic [2:0]       level;
    seg_buf_t         segs;
  } job_t;

  function automatic logic [7:0] encode_char(input logic [7:0] c);
    logic [7:0] ofs;
    ofs = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      ofs = c - 8'd48;
      return GLYPH[ofs[5:0]];
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      ofs = c - 8'd55;
      return GLYPH[ofs[5:0]];
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      ofs = c - 8'd87;
      return GLYPH[ofs[5:0]];
    end else if (c == CH_DASH) begin
      return DASH_SEG;
    end
    return 8'h00;
  endfunction

  function automatic logic [SLOT_W-1:0] first_slot(input logic [SLOTS-1:0] m);
    logic [SLOT_W-1:0] r;
    r = SLOT_W'(SLOTS - 1);
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (m[k]) r = SLOT_W'(k);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/ssbrc_text_enc.sv =====
// ----------------------------------------------------------------------------
// ssbrc_text_enc
// Packs up to six text characters into the digit buffer, folding a trailing
// dot into the digit before it.
// ----------------------------------------------------------------------------
`default_nettype none

module ssbrc_text_enc (
  input  wire logic [ssbrc_pkg::TEXT_CHARS-1:0][7:0] text,
  input  wire ssbrc_pkg::seg_buf_t                   shown_i,
  output ssbrc_pkg::seg_buf_t                        shown_o
);

  logic [ssbrc_pkg::TEXT_CHARS:0][7:0] txt;

  assign txt = {ssbrc_pkg::CH_NUL, text};

  always_comb begin
    ssbrc_pkg::seg_buf_t           work;
    logic [ssbrc_pkg::DIDX_W-1:0]  n;
    logic                          stop;
    logic                          adv;
    work    = '0;
    n       = '0;
    stop    = 1'b0;
    adv     = 1'b0;
    shown_o = shown_i;
    for (int i = 0; i < ssbrc_pkg::TEXT_CHARS; i++) begin
      if (txt[i] == ssbrc_pkg::CH_NUL) stop = 1'b1;
      if (!stop) begin
        work[n] = work[n] | ssbrc_pkg::encode_char(txt[i]);
        if (txt[i] == ssbrc_pkg::CH_DOT) begin
          work[n] = work[n] | ssbrc_pkg::DOT_SEG;
          adv = 1'b1;
        end else begin
          // a dot right after a character joins that character's digit
          adv = (txt[i+1] != ssbrc_pkg::CH_DOT);
        end
        if (adv) begin
          shown_o[n] = work[n];
          n = n + 1'b1;
          if (n >= ssbrc_pkg::DIDX_W'(ssbrc_pkg::DIGITS)) stop = 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/ssbrc_refresh.sv =====
// ----------------------------------------------------------------------------
// ssbrc_refresh
// Input register, display state and the per-tick refresh planner that
// decides which driver writes a tick causes.
// ----------------------------------------------------------------------------
`default_nettype none

module ssbrc_refresh (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic                                   in_func,
  input  wire logic [ssbrc_pkg::TEXT_CHARS-1:0][7:0]  in_text,
  input  wire logic                                   in_display_on,
  input  wire logic [2:0]                             in_brightness,
  input  wire logic                                   in_blink_on,
  input  wire logic                                   emit_free,
  output logic                                        job_load,
  output ssbrc_pkg::job_t                             job
);

  // input register
  logic                                      in_vld_r;
  logic                                      func_r;
  logic [ssbrc_pkg::TEXT_CHARS-1:0][7:0]     text_r;
  logic                                      disp_on_r;
  logic [2:0]                                bright_r;
  logic                                      blink_on_r;

  // display state
  ssbrc_pkg::seg_buf_t shown_r, shown_nxt;
  ssbrc_pkg::seg_buf_t sent_r, sent_nxt;
  logic                disp_en_r, disp_en_nxt;
  logic                prev_en_r, prev_en_nxt;
  logic                blink_mode_r, blink_mode_nxt;
  logic                pending_r, pending_nxt;
  logic [6:0]          cnt_r, cnt_nxt;
  logic [2:0]          level_now_r, level_now_nxt;
  logic [2:0]          level_prev_r, level_prev_nxt;
  logic [7:0]          timer_r, timer_nxt;

  ssbrc_pkg::seg_buf_t enc_shown;

  // tick plan
  ssbrc_pkg::seg_buf_t tk_sent;
  logic                tk_disp_en;
  logic                tk_prev_en;
  logic                tk_pending;
  logic [6:0]          tk_cnt;
  logic [2:0]          tk_level_prev;
  logic [7:0]          tk_timer;

  logic adv;
  logic step_set;
  logic step_tick;

  ssbrc_text_enc u_enc (
    .text    (text_r),
    .shown_i (shown_r),
    .shown_o (enc_shown)
  );

  always_comb begin
    logic [6:0] cnt_step;
    cnt_step      = cnt_r;
    tk_sent       = sent_r;
    tk_disp_en    = disp_en_r;
    tk_prev_en    = prev_en_r;
    tk_pending    = pending_r;
    tk_cnt        = cnt_r;
    tk_level_prev = level_prev_r;
    tk_timer      = timer_r;
    job           = '0;
    job.level     = level_now_r;
    job.segs      = shown_r;
    if (disp_en_r) begin
      if (!blink_mode_r) begin
        if (shown_r != sent_r || pending_r || !prev_en_r) begin
          job.vld[ssbrc_pkg::SLOT_MODE] = 1'b1;
          job.en[ssbrc_pkg::SLOT_MODE]  = 1'b1;
          tk_sent    = shown_r;
          tk_pending = 1'b0;
        end
      end else begin
        if (cnt_r <= ssbrc_pkg::BLINK_LIMIT) begin
          cnt_step = cnt_r + 7'd1;
          if (cnt_step == ssbrc_pkg::BLINK_LIMIT) begin
            job.vld[ssbrc_pkg::SLOT_MODE]   = 1'b1;
            job.en[ssbrc_pkg::SLOT_MODE]    = 1'b1;
            job.blank[ssbrc_pkg::SLOT_MODE] = 1'b1;
            cnt_step = '0;
          end
        end
        if (cnt_step == ssbrc_pkg::BLINK_SHOW) begin
          job.vld[ssbrc_pkg::SLOT_MODE] = 1'b1;
          job.en[ssbrc_pkg::SLOT_MODE]  = 1'b1;
        end
        tk_cnt     = cnt_step;
        tk_pending = 1'b1;
      end
      if (level_prev_r != level_now_r) begin
        // only the control word goes out when the display was just off
        job.vld[ssbrc_pkg::SLOT_LEVEL] = 1'b1;
        job.en[ssbrc_pkg::SLOT_LEVEL]  = prev_en_r;
        tk_level_prev = level_now_r;
      end
      tk_prev_en = 1'b1;
    end else if (prev_en_r) begin
      job.vld[ssbrc_pkg::SLOT_MODE]   = 1'b1;
      job.en[ssbrc_pkg::SLOT_MODE]    = 1'b1;
      job.blank[ssbrc_pkg::SLOT_MODE] = 1'b1;
      tk_prev_en = 1'b0;
    end
    if (timer_r > 8'd1) begin
      tk_timer = timer_r - 8'd1;
      if (tk_timer == 8'd1) begin
        tk_timer   = '0;
        tk_disp_en = 1'b0;
        job.vld[ssbrc_pkg::SLOT_STARTUP]   = 1'b1;
        job.en[ssbrc_pkg::SLOT_STARTUP]    = 1'b1;
        job.blank[ssbrc_pkg::SLOT_STARTUP] = 1'b1;
      end
    end
  end

  // a tick with writes waits until the output sequencer can take them
  assign adv       = (func_r == ssbrc_pkg::FUNC_SET) || (job.vld == '0) || emit_free;
  assign in_stall  = in_vld_r && !adv;
  assign step_set  = in_vld_r && (func_r == ssbrc_pkg::FUNC_SET);
  assign step_tick = in_vld_r && (func_r == ssbrc_pkg::FUNC_TICK) && adv;
  assign job_load  = step_tick && (job.vld != '0);

  always_comb begin
    shown_nxt      = shown_r;
    sent_nxt       = sent_r;
    disp_en_nxt    = disp_en_r;
    prev_en_nxt    = prev_en_r;
    blink_mode_nxt = blink_mode_r;
    pending_nxt    = pending_r;
    cnt_nxt        = cnt_r;
    level_now_nxt  = level_now_r;
    level_prev_nxt = level_prev_r;
    timer_nxt      = timer_r;
    if (step_set) begin
      shown_nxt      = enc_shown;
      blink_mode_nxt = blink_on_r;
      disp_en_nxt    = disp_on_r;
      level_now_nxt  = bright_r;
    end else if (step_tick) begin
      sent_nxt       = tk_sent;
      disp_en_nxt    = tk_disp_en;
      prev_en_nxt    = tk_prev_en;
      pending_nxt    = tk_pending;
      cnt_nxt        = tk_cnt;
      level_prev_nxt = tk_level_prev;
      timer_nxt      = tk_timer;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r     <= 1'b0;
      shown_r      <= {ssbrc_pkg::DIGITS{ssbrc_pkg::SHOWN_RST}};
      sent_r       <= '0;
      disp_en_r    <= 1'b1;
      prev_en_r    <= 1'b1;
      blink_mode_r <= 1'b0;
      pending_r    <= 1'b0;
      cnt_r        <= '0;
      level_now_r  <= ssbrc_pkg::LEVEL_RST;
      level_prev_r <= ssbrc_pkg::LEVEL_RST;
      timer_r      <= ssbrc_pkg::STARTUP_TICKS;
    end else begin
      if (in_valid && !in_stall) begin
        in_vld_r <= 1'b1;
      end else if (adv) begin
        in_vld_r <= 1'b0;
      end
      shown_r      <= shown_nxt;
      sent_r       <= sent_nxt;
      disp_en_r    <= disp_en_nxt;
      prev_en_r    <= prev_en_nxt;
      blink_mode_r <= blink_mode_nxt;
      pending_r    <= pending_nxt;
      cnt_r        <= cnt_nxt;
      level_now_r  <= level_now_nxt;
      level_prev_r <= level_prev_nxt;
      timer_r      <= timer_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      func_r     <= in_func;
      text_r     <= in_text;
      disp_on_r  <= in_display_on;
      bright_r   <= in_brightness;
      blink_on_r <= in_blink_on;
    end
  end

`ifndef SYNTHESIS
  a_timer_skips_one: assert property (@(posedge clk) disable iff (!rst_n)
    timer_r != 8'd1)
    else $error("startup timer parked at one");
  a_blink_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < ssbrc_pkg::BLINK_LIMIT)
    else $error("blink counter out of range");
  a_load_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    job_load |-> in_vld_r && emit_free)
    else $error("job load without a pending tick item");
`endif

endmodule

`default_nettype wire

// ===== src/ssbrc_emit.sv =====
// ----------------------------------------------------------------------------
// ssbrc_emit
// Output sequencer: holds one tick's planned writes and sends them out one
// word per cycle while out_stall is low, each control word first, then its digits.
// ----------------------------------------------------------------------------
`default_nettype none

module ssbrc_emit (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            job_load,
  input  wire ssbrc_pkg::job_t job,
  output logic                 emit_free,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic                 out_write_kind,
  output logic [2:0]           out_level,
  output logic                 out_enable,
  output logic [1:0]           out_digit_position,
  output logic [7:0]           out_segments,
  output logic                 out_last
);

  ssbrc_pkg::job_t                 job_r;
  logic                            vld_r;
  logic [ssbrc_pkg::SLOT_W-1:0]    slot_r;
  logic [ssbrc_pkg::DIDX_W-1:0]    sub_r;
  logic [ssbrc_pkg::SLOTS-1:0]     rest;
  logic [ssbrc_pkg::DIDX_W-1:0]    didx;
  logic                            digits_done;
  logic                            fire;

  always_comb begin
    for (int k = 0; k < ssbrc_pkg::SLOTS; k++) begin
      rest[k] = job_r.vld[k] && (ssbrc_pkg::SLOT_W'(k) > slot_r);
    end
  end

  assign didx        = sub_r - 1'b1;
  assign digits_done = (sub_r == ssbrc_pkg::DIDX_W'(ssbrc_pkg::DIGITS)) ||
                       (sub_r == '0 && !job_r.en[slot_r]);
  assign fire        = vld_r && !out_stall;
  assign emit_free   = !vld_r || (fire && out_last);

  assign out_valid          = vld_r;
  assign out_write_kind     = (sub_r == '0) ? ssbrc_pkg::WK_CTRL : ssbrc_pkg::WK_DIGIT;
  assign out_level          = (sub_r == '0) ? job_r.level : 3'd0;
  assign out_enable         = (sub_r == '0) ? job_r.en[slot_r] : 1'b0;
  // buffer digit i goes to driver address 3-i
  assign out_digit_position = (sub_r == '0) ? 2'd0 : ssbrc_pkg::TOP_POS - didx[1:0];
  assign out_segments       = (sub_r == '0 || job_r.blank[slot_r]) ? 8'h00 :
                              job_r.segs[didx];
  assign out_last           = digits_done && (rest == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      slot_r <= '0;
      sub_r  <= '0;
    end else if (job_load) begin
      vld_r  <= 1'b1;
      slot_r <= ssbrc_pkg::first_slot(job.vld);
      sub_r  <= '0;
    end else if (fire) begin
      if (!digits_done) begin
        sub_r <= sub_r + 1'b1;
      end else if (rest != '0) begin
        slot_r <= ssbrc_pkg::first_slot(rest);
        sub_r  <= '0;
      end else begin
        vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_load) begin
      job_r <= job;
    end
  end

`ifndef SYNTHESIS
  a_slot_live: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> job_r.vld[slot_r])
    else $error("sequencer on an empty slot");
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    job_load |-> emit_free)
    else $error("job loaded over unfinished writes");
  a_sub_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> sub_r <= ssbrc_pkg::DIDX_W'(ssbrc_pkg::DIGITS))
    else $error("digit index out of range");
`endif

endmodule

`default_nettype wire

// ===== src/seven_segment_blink_refresh_ctrl.sv =====
// ----------------------------------------------------------------------------
// seven_segment_blink_refresh_ctrl
// Three-digit seven-segment display controller with text loading, blink,
// brightness rewrite, switch-off blanking and a startup off timer.
//
//   channel | dir | handshake          | payload
//   in_     | in  | in_valid/in_stall  | func, char0..5, display_on,
//           |     |                    | brightness, blink_on
//   out_    | out | out_valid/out_stall| write_kind, level, enable,
//           |     |                    | digit_position, segments, last
//
// An item is held in the input register; a tick's driver writes are then
// loaded into the output sequencer, which sends one word per cycle while
// out_stall is low: a control word, then three digit words if enabled.
// Set items and ticks with no writes leave without loading the sequencer.
// Reset (synchronous, rst_n low) restores the power-on display state.
// A stalled output holds its write; a tick with writes waits in the input
// register until the sequencer has sent the last write of the previous tick.
// ----------------------------------------------------------------------------
`default_nettype none

module seven_segment_blink_refresh_ctrl (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       in_func,
  input  wire logic [7:0] in_char0,
  input  wire logic [7:0] in_char1,
  input  wire logic [7:0] in_char2,
  input  wire logic [7:0] in_char3,
  input  wire logic [7:0] in_char4,
  input  wire logic [7:0] in_char5,
  input  wire logic       in_display_on,
  input  wire logic [2:0] in_brightness,
  input  wire logic       in_blink_on,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_write_kind,
  output logic [2:0]      out_level,
  output logic            out_enable,
  output logic [1:0]      out_digit_position,
  output logic [7:0]      out_segments,
  output logic            out_last
);

  logic [ssbrc_pkg::TEXT_CHARS-1:0][7:0] text;
  ssbrc_pkg::job_t                       job;
  logic                                  job_load;
  logic                                  emit_free;

  assign text = {in_char5, in_char4, in_char3, in_char2, in_char1, in_char0};

  ssbrc_refresh u_refresh (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_func       (in_func),
    .in_text       (text),
    .in_display_on (in_display_on),
    .in_brightness (in_brightness),
    .in_blink_on   (in_blink_on),
    .emit_free     (emit_free),
    .job_load      (job_load),
    .job           (job)
  );

  ssbrc_emit u_emit (
    .clk                (clk),
    .rst_n              (rst_n),
    .job_load           (job_load),
    .job                (job),
    .emit_free          (emit_free),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_write_kind     (out_write_kind),
    .out_level          (out_level),
    .out_enable         (out_enable),
    .out_digit_position (out_digit_position),
    .out_segments       (out_segments),
    .out_last           (out_last)
  );

endmodule

`default_nettype wire

// ===== tb/seven_segment_blink_refresh_ctrl_tb.sv =====
// ----------------------------------------------------------------------------
// seven_segment_blink_refresh_ctrl_tb
// Self-checking bench for the three-digit display controller. A queue of
// text/mode and refresh-tick items feeds a clocked driver. An in-bench
// predictor tracks the digit buffer, blink, brightness and power-on timer
// and lists the driver writes each tick must cause. A clocked monitor
// compares every write field by field. Both sides idle and stall at random.
// ----------------------------------------------------------------------------

module seven_segment_blink_refresh_ctrl_tb;

  import ssbrc_pkg::FUNC_TICK;
  import ssbrc_pkg::FUNC_SET;
  import ssbrc_pkg::WK_CTRL;
  import ssbrc_pkg::WK_DIGIT;
  import ssbrc_pkg::DIGITS;
  import ssbrc_pkg::TEXT_CHARS;

  localparam int       ITEM_TARGET    = 430;
  localparam int       TIMEOUT        = 4_000_000;
  localparam int       DRAIN_CYCLES   = 24;
  localparam int       MAX_WAIT       = 6;
  localparam int       FAST_RUN_MAX   = 8;

  localparam logic [7:0] ASCII_NUL    = 8'h00;
  localparam logic [7:0] ASCII_DOT    = 8'h2E;
  localparam logic [7:0] ASCII_DASH   = 8'h2D;
  localparam logic [7:0] SEG_DP       = 8'h80;
  localparam logic [7:0] SEG_DASH     = 8'h40;
  localparam logic [6:0] BLINK_PERIOD = 7'd100;
  localparam logic [6:0] BLINK_HALF   = 7'd50;
  localparam logic [7:0] POWER_ON_TICKS = 8'd200;
  localparam logic [2:0] RESET_LEVEL  = 3'd7;
  localparam logic [1:0] POS_TOP      = 2'd3;

  // digits 0-9 then letters a-z
  localparam logic [0:35][7:0] SEG_FONT = {
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F,
    8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h3D, 8'h76, 8'h19, 8'h0D,
    8'h72, 8'h38, 8'h55, 8'h54, 8'h5D, 8'h73, 8'h67, 8'h50, 8'h6D, 8'h78,
    8'h3E, 8'h1C, 8'h6A, 8'h1D, 8'h6E, 8'h49
  };

  typedef logic [DIGITS-1:0][7:0] digit_buf_t;

  typedef struct packed {
    logic                      func;
    logic [TEXT_CHARS-1:0][7:0] chars;
    logic                      display_on;
    logic [2:0]                brightness;
    logic                      blink_on;
  } cmd_t;

  typedef struct packed {
    logic       write_kind;
    logic [2:0] level;
    logic       enable;
    logic [1:0] digit_position;
    logic [7:0] segments;
    logic       last;
  } write_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_func = 1'b0;
  logic [7:0] in_char0 = 8'd0;
  logic [7:0] in_char1 = 8'd0;
  logic [7:0] in_char2 = 8'd0;
  logic [7:0] in_char3 = 8'd0;
  logic [7:0] in_char4 = 8'd0;
  logic [7:0] in_char5 = 8'd0;
  logic       in_display_on = 1'b0;
  logic [2:0] in_brightness = 3'd0;
  logic       in_blink_on = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_write_kind;
  logic [2:0] out_level;
  logic       out_enable;
  logic [1:0] out_digit_position;
  logic [7:0] out_segments;
  logic       out_last;

  seven_segment_blink_refresh_ctrl dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_func            (in_func),
    .in_char0           (in_char0),
    .in_char1           (in_char1),
    .in_char2           (in_char2),
    .in_char3           (in_char3),
    .in_char4           (in_char4),
    .in_char5           (in_char5),
    .in_display_on      (in_display_on),
    .in_brightness      (in_brightness),
    .in_blink_on        (in_blink_on),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_write_kind     (out_write_kind),
    .out_level          (out_level),
    .out_enable         (out_enable),
    .out_digit_position (out_digit_position),
    .out_segments       (out_segments),
    .out_last           (out_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // display state as the predictor sees it
  digit_buf_t shown_buf   = {DIGITS{8'hFF}};
  digit_buf_t sent_buf    = '0;
  logic       disp_en     = 1'b1;
  logic       prev_en     = 1'b1;
  logic       blink_mode  = 1'b0;
  logic       blink_pend  = 1'b0;
  logic [6:0] blink_cnt   = 7'd0;
  logic [2:0] lvl_now     = RESET_LEVEL;
  logic [2:0] lvl_prev    = RESET_LEVEL;
  logic [7:0] power_timer = POWER_ON_TICKS;

  cmd_t   pending_cmds [$];
  write_t expected_writes [$];
  cmd_t   in_item;
  write_t got_write;
  write_t want_write;
  int     items_done = 0;
  int     mismatches = 0;
  int     in_wait = 0;
  int     out_wait = 0;
  bit     in_burst = 1'b0;
  bit     out_burst = 1'b0;

  function automatic logic [7:0] glyph_of(input logic [7:0] ch);
    if (ch >= 8'h30 && ch <= 8'h39) return SEG_FONT[ch - 8'h30];
    if (ch >= 8'h41 && ch <= 8'h5A) return SEG_FONT[ch - 8'd55];
    if (ch >= 8'h61 && ch <= 8'h7A) return SEG_FONT[ch - 8'd87];
    if (ch == ASCII_DASH) return SEG_DASH;
    return 8'h00;
  endfunction

  // one driver write: control word, then the digits when enabled
  function automatic void emit_refresh(input bit blank, input logic en);
    write_t w;
    int     i;
    w = {WK_CTRL, lvl_now, en, 2'd0, 8'd0, 1'b0};
    expected_writes.push_back(w);
    if (en) begin
      for (i = 0; i < DIGITS; i++) begin
        w = {WK_DIGIT, 3'd0, 1'b0, 2'(POS_TOP - i), blank ? 8'd0 : shown_buf[i], 1'b0};
        expected_writes.push_back(w);
      end
    end
  endfunction

  function automatic void predict_writes(input cmd_t c);
    int                       base;
    int                       k;
    int                       n;
    bit                       done;
    bit                       step;
    logic [TEXT_CHARS:0][7:0] txt;
    digit_buf_t               acc;
    write_t                   w;
    base = expected_writes.size();
    if (c.func == FUNC_SET) begin
      txt = {ASCII_NUL, c.chars};
      acc = '0;
      n = 0;
      done = 1'b0;
      for (k = 0; k < TEXT_CHARS && !done; k++) begin
        if (txt[k] == ASCII_NUL) begin
          done = 1'b1;
        end else begin
          acc[n] = acc[n] | glyph_of(txt[k]);
          // a dot joins the digit before it unless that digit is already closed
          if (txt[k] == ASCII_DOT) begin
            acc[n] = acc[n] | SEG_DP;
            step = 1'b1;
          end else begin
            step = (txt[k + 1] != ASCII_DOT);
          end
          if (step) begin
            shown_buf[n] = acc[n];
            n++;
            if (n >= DIGITS) done = 1'b1;
          end
        end
      end
      blink_mode = c.blink_on;
      disp_en = c.display_on;
      lvl_now = c.brightness;
    end else begin
      if (disp_en) begin
        if (!blink_mode) begin
          if (shown_buf != sent_buf || blink_pend || !prev_en) begin
            emit_refresh(1'b0, 1'b1);
            sent_buf = shown_buf;
            blink_pend = 1'b0;
          end
        end else begin
          if (blink_cnt <= BLINK_PERIOD) begin
            blink_cnt++;
            if (blink_cnt == BLINK_PERIOD) begin
              emit_refresh(1'b1, 1'b1);
              blink_cnt = 7'd0;
            end
          end
          if (blink_cnt == BLINK_HALF) emit_refresh(1'b0, 1'b1);
          blink_pend = 1'b1;
        end
        // brightness rewrite carries the enable from before this tick
        if (lvl_prev != lvl_now) begin
          emit_refresh(1'b0, prev_en);
          lvl_prev = lvl_now;
        end
        prev_en = disp_en;
      end else if (prev_en) begin
        emit_refresh(1'b1, 1'b1);
        prev_en = 1'b0;
      end
      if (power_timer > 8'd1) begin
        power_timer--;
        if (power_timer == 8'd1) begin
          power_timer = 8'd0;
          disp_en = 1'b0;
          emit_refresh(1'b1, 1'b1);
        end
      end
    end
    if (expected_writes.size() > base) begin
      w = expected_writes.pop_back();
      w.last = 1'b1;
      expected_writes.push_back(w);
    end
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic int draw_wait(input bit burst);
    return burst ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic void queue_set(input logic [7:0] c0, input logic [7:0] c1,
                                    input logic [7:0] c2, input logic [7:0] c3,
                                    input logic [7:0] c4, input logic [7:0] c5,
                                    input logic on, input logic [2:0] bri,
                                    input logic blink);
    cmd_t c;
    c.func = FUNC_SET;
    c.chars = {c5, c4, c3, c2, c1, c0};
    c.display_on = on;
    c.brightness = bri;
    c.blink_on = blink;
    pending_cmds.push_back(c);
  endfunction

  // tick items carry random content in the fields they ignore
  function automatic void queue_tick();
    cmd_t c;
    c.chars = 48'({$urandom, $urandom});
    c.display_on = 1'($urandom_range(0, 1));
    c.brightness = 3'($urandom_range(0, 7));
    c.blink_on = 1'($urandom_range(0, 1));
    c.func = FUNC_TICK;
    pending_cmds.push_back(c);
  endfunction

  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 9))
      0, 1:    return 8'($urandom_range(8'h30, 8'h39));
      2:       return 8'($urandom_range(8'h41, 8'h5A));
      3:       return 8'($urandom_range(8'h61, 8'h7A));
      4, 5:    return ASCII_DOT;
      6:       return ASCII_NUL;
      7:       return $urandom_range(0, 1) ? ASCII_DASH : 8'h20;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // driver: payload only moves when the current item is taken or none is up
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_writes(in_item);
        items_done++;
      end
      if (!in_valid || !in_stall) begin
        if (in_wait > 0) begin
          in_wait--;
          in_valid <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          in_item = pending_cmds.pop_front();
          in_func <= in_item.func;
          in_char0 <= in_item.chars[0];
          in_char1 <= in_item.chars[1];
          in_char2 <= in_item.chars[2];
          in_char3 <= in_item.chars[3];
          in_char4 <= in_item.chars[4];
          in_char5 <= in_item.chars[5];
          in_display_on <= in_item.display_on;
          in_brightness <= in_item.brightness;
          in_blink_on <= in_item.blink_on;
          in_valid <= 1'b1;
          if ($urandom_range(0, 31) == 0) in_burst = !in_burst;
          in_wait = draw_wait(in_burst);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and stall generator
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got_write = {out_write_kind, out_level, out_enable, out_digit_position,
                     out_segments, out_last};
        if (expected_writes.size() == 0) begin
          $error("unexpected write: kind %0d position %0d segments %h",
                 out_write_kind, out_digit_position, out_segments);
          mismatches++;
        end else begin
          want_write = expected_writes.pop_front();
          check_field("write_kind", want_write.write_kind, got_write.write_kind);
          check_field("level", want_write.level, got_write.level);
          check_field("enable", want_write.enable, got_write.enable);
          check_field("digit_position", want_write.digit_position,
                      got_write.digit_position);
          check_field("segments", want_write.segments, got_write.segments);
          check_field("last", want_write.last, got_write.last);
        end
        if ($urandom_range(0, 31) == 0) out_burst = !out_burst;
        out_wait = draw_wait(out_burst);
      end
      if (out_wait > 0) begin
        out_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    int   total;
    int   run_len;
    int   k;
    logic on_flag;

    // power-on buffer differs from what was sent
    queue_tick();
    queue_set("8", ".", "8", ".", "8", ".", 1'b1, 3'd7, 1'b0);
    queue_tick();
    queue_set("-", "a", "Z", ASCII_NUL, "q", "q", 1'b1, 3'd0, 1'b0);
    queue_tick();
    // lone dots take digits of their own
    queue_set(".", ".", "1", ASCII_NUL, ASCII_NUL, ASCII_NUL, 1'b1, 3'd0, 1'b0);
    queue_tick();
    // switch-off blanks once, then stays quiet
    queue_set(" ", " ", " ", ASCII_NUL, ASCII_NUL, ASCII_NUL, 1'b0, 3'd0, 1'b0);
    queue_tick();
    queue_tick();
    // back on with a new level: rewrite, then a control word with enable low
    queue_set("a", ".", "b", ".", "c", ".", 1'b1, 3'd3, 1'b0);
    queue_tick();
    queue_set(8'hFF, 8'h80, 8'h7F, ".", 8'h01, ".", 1'b1, 3'd4, 1'b1);
    queue_tick();
    queue_tick();
    // leaving blink mode forces a rewrite
    queue_set("1", "2", "3", "4", "5", "6", 1'b1, 3'd4, 1'b0);
    queue_tick();
    queue_set("A", ".", ".", "b", "-", ".", 1'b1, 3'd7, 1'b0);
    queue_tick();
    queue_tick();

    while (pending_cmds.size() < ITEM_TARGET) begin
      if ($urandom_range(0, 3) == 0) begin
        // long blink stretch so the counter reaches show and blank points
        queue_set(pick_char(), pick_char(), pick_char(), pick_char(), pick_char(),
                  pick_char(), 1'b1, 3'($urandom_range(0, 7)), 1'b1);
        run_len = $urandom_range(40, 110);
      end else begin
        on_flag = ($urandom_range(0, 7) != 0);
        queue_set(pick_char(), pick_char(), pick_char(), pick_char(), pick_char(),
                  pick_char(), on_flag, 3'($urandom_range(0, 7)),
                  1'($urandom_range(0, 1)));
        run_len = $urandom_range(0, FAST_RUN_MAX);
      end
      for (k = 0; k < run_len && pending_cmds.size() < ITEM_TARGET; k++) queue_tick();
    end
    total = pending_cmds.size();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (items_done < total || expected_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_writes.size() == 0) begin
      $display("PASS seven_segment_blink_refresh_ctrl");
    end else begin
      $display("FAIL seven_segment_blink_refresh_ctrl");
    end
    $finish;
  end

  initial begin
    #TIMEOUT;
    $display("FAIL seven_segment_blink_refresh_ctrl");
    $finish;
  end

endmodule

// ===== sim.f =====
src/ssbrc_pkg.sv
src/ssbrc_text_enc.sv
src/ssbrc_refresh.sv
src/ssbrc_emit.sv
src/seven_segment_blink_refresh_ctrl.sv
tb/seven_segment_blink_refresh_ctrl_tb.sv
